>>> sv/haversine_distance_average_defines.svh
// Assertion macros shared by the haversine distance average checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef HAVERSINE_DISTANCE_AVERAGE_DEFINES_SVH
`define HAVERSINE_DISTANCE_AVERAGE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HDA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hda_pkg.sv
// Types, constants and elaboration-time tables for the haversine distance average block.
// Used by haversine_distance_average; depends on nothing else.
package hda_pkg;

    localparam int CORDIC_STEPS = 32;
    localparam int CI_W = $clog2(CORDIC_STEPS);
    localparam int MAX_PAIRS = 1048576;
    localparam logic [20:0] COUNT_LIMIT = 21'((MAX_PAIRS < 2097151) ? MAX_PAIRS : 2097151);

    localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
    localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

    localparam logic signed [30:0] DEG_QUARTER = 31'sd94371840;
    localparam logic signed [30:0] DEG_HALF = 31'sd188743680;
    localparam logic signed [30:0] DEG_FULL = 31'sd377487360;

    localparam logic [63:0] K_DEG = (PI_Q60 + 64'd94371840) / 64'd188743680;

    localparam logic [51:0] SUM_MAX = '1;
    localparam logic [31:0] DIST_MAX = '1;
    localparam logic [30:0] RADIUS_RESET = 31'd417647821;

    typedef logic [63:0] atan_tab_t [CORDIC_STEPS];

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_ZSET,
        ST_CORD,
        ST_RPOST,
        ST_SQSAVE,
        ST_PROD1,
        ST_PROD2,
        ST_SQRT,
        ST_ANG,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MSH_0,
        MSH_59,
        MSH_60
    } mul_shift_t;

    // Shift-and-subtract quotient, evaluated during elaboration only.
    function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        int b;
        rem = '0;
        q = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] cmulshr(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[63 + s -: 64];
    endfunction

    function automatic atan_tab_t build_atan();
        atan_tab_t tab;
        logic [63:0] acc;
        logic [63:0] term;
        int i;
        int k;
        int e;
        for (i = 0; i < CORDIC_STEPS; i++)
        begin
            acc = '0;
            if (i == 0)
            begin
                acc = PI_Q60 >> 2;
            end
            else
            begin
                for (k = 0; k < 31; k++)
                begin
                    e = 60 - i * (2 * k + 1);
                    if (e >= 0)
                    begin
                        term = cdiv(64'd1 << e, 64'(2 * k + 1));
                        acc = k[0] ? acc - term : acc + term;
                    end
                end
            end
            tab[i] = acc;
        end
        return tab;
    endfunction

    function automatic logic [63:0] build_inv_gain();
        logic [63:0] a2;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] u;
        int i;
        int n;
        a2 = ONE_Q60;
        for (i = 0; i < CORDIC_STEPS; i++)
        begin
            if (2 * i < 61)
            begin
                a2 = a2 + (a2 >> (2 * i));
            end
        end
        r = 64'h0999_9999_9999_9999;
        for (n = 0; n < 12; n++)
        begin
            t = cmulshr(a2, cmulshr(r, r, 60), 60);
            u = 64'h3000_0000_0000_0000 - t;
            r = cmulshr(r, u, 60) >> 1;
        end
        return r;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan();
    localparam logic [63:0] INV_GAIN = build_inv_gain();

    // Magnitude of a signed Q60 value, limited to one.
    function automatic logic [60:0] mag_clamp(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        return (m > ONE_Q60) ? ONE_Q60[60:0] : m[60:0];
    endfunction

endpackage

>>> sv/haversine_distance_average.sv
// Haversine great-circle distance averaged over batches of coordinate pairs.
// Depends on hda_pkg for constants, CORDIC tables and the sequencer states.
//
// Usage: each input item on the s_axis channel carries one start/end point pair in
// units of 2^-20 degree; tlast marks the final pair of a batch. The block is ready
// only when its sequencer is idle. Each item runs four CORDIC rotations and one
// vectoring run of 32 steps on the shared CORDIC datapath, two 61-step bit-serial
// square roots, and several products on a 32x32 multiplier that builds each product
// from four partial products.
// An item with tlast adds a 52-bit restoring divide and then writes the average
// distance, the pair count and the overflow flag into the m_axis output register.
// If that register still holds an untaken result, the sequencer waits there; input
// stays stalled until the old result is taken. A result waiting on the output does
// not block acceptance of the next input item otherwise.
// The APB port holds the sphere radius at address 0; write it only while idle.
// Reset clears the batch sum, count and overflow flag, empties the output register
// and sets the radius to 6372.8 km.
module haversine_distance_average
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // lon_start[28:0], lat_start[56:29], lon_end[85:57], lat_end[113:86], zero pad
    input  logic [119:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // average_distance[31:0], pair_count[52:32], zero pad
    output logic [55:0]  m_axis_tdata,
    // overflow[0]
    output logic         m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    hda_pkg::state_t state_reg, state_next;
    hda_pkg::state_t mul_ret_reg, mul_ret_next;
    hda_pkg::mul_shift_t mul_sh_reg, mul_sh_next;

    logic [28:0] lon0_reg, lon0_next, lon1_reg, lon1_next;
    logic [27:0] lat0_reg, lat0_next, lat1_reg, lat1_next;
    logic        last_reg, last_next;
    logic [1:0]  job_reg, job_next;
    logic        ang_neg_reg, ang_neg_next;
    logic        fold_neg_reg, fold_neg_next;

    logic [63:0]  mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic [127:0] mul_acc_reg, mul_acc_next;
    logic [1:0]   mul_cnt_reg, mul_cnt_next;

    logic signed [63:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [hda_pkg::CI_W-1:0] ci_reg, ci_next;
    logic vec_reg, vec_next;

    logic [60:0] sq_lat_reg, sq_lat_next, sq_lon_reg, sq_lon_next;
    logic [60:0] c0_reg, c0_next;
    logic        c0_neg_reg, c0_neg_next, c1_neg_reg, c1_neg_next;
    logic [60:0] ua_reg, ua_next;
    logic [60:0] root_reg, root_next;

    logic [121:0] sr_n_reg, sr_n_next;
    logic [63:0]  sr_rem_reg, sr_rem_next;
    logic [60:0]  sr_root_reg, sr_root_next;
    logic [5:0]   sr_cnt_reg, sr_cnt_next;
    logic         sr_second_reg, sr_second_next;

    logic [51:0] sum_reg, sum_next;
    logic [20:0] count_reg, count_next;
    logic        sat_reg, sat_next;

    logic [51:0] dv_q_reg, dv_q_next;
    logic [21:0] dv_rem_reg, dv_rem_next;
    logic [5:0]  dv_cnt_reg, dv_cnt_next;

    logic [30:0] radius_reg, radius_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_avg_reg, out_avg_next;
    logic [20:0] out_cnt_reg, out_cnt_next;
    logic        out_ovf_reg, out_ovf_next;

    // Shared multiplier datapath.
    logic [31:0]  a_part, b_part;
    logic [63:0]  pp;
    logic [1:0]   pp_pos;
    logic [63:0]  mul_res;

    // Shared CORDIC datapath.
    logic signed [63:0] dx, dy, atan_v, x_step, y_step, z_step;
    logic               dir;

    // Angle reduction.
    logic signed [30:0] rv, r1, r2, r3;
    logic               fneg;
    logic [29:0]        rmag;

    // Square root step.
    logic [63:0]  rem_sh, trial;
    logic         sr_ge;
    logic [60:0]  root_step;
    logic [60:0]  sr_in;
    logic [121:0] sr_init;

    // Divider step.
    logic [21:0] dv_sh;
    logic        dv_ge;

    // Misc.
    logic signed [63:0] zs, z0;
    logic [60:0]        cm;
    logic signed [62:0] a_sum;
    logic [60:0]        ua_c;
    logic [63:0]        dist_c;
    logic [31:0]        d32;
    logic               dsat;
    logic               cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {1'b0, radius_reg};

    assign s_axis_tready = (state_reg == hda_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {3'b000, out_cnt_reg, out_avg_reg};
    assign m_axis_tuser = out_ovf_reg;

    always_comb
    begin
        a_part = mul_cnt_reg[1] ? mul_a_reg[63:32] : mul_a_reg[31:0];
        b_part = mul_cnt_reg[0] ? mul_b_reg[63:32] : mul_b_reg[31:0];
        pp = {32'b0, a_part} * {32'b0, b_part};
        pp_pos = {1'b0, mul_cnt_reg[1]} + {1'b0, mul_cnt_reg[0]};
        case (mul_sh_reg)
            hda_pkg::MSH_59: mul_res = mul_acc_reg[122:59];
            hda_pkg::MSH_60: mul_res = mul_acc_reg[123:60];
            default:         mul_res = mul_acc_reg[63:0];
        endcase
    end

    always_comb
    begin
        dx = cy_reg >>> ci_reg;
        dy = cx_reg >>> ci_reg;
        atan_v = $signed(hda_pkg::ATAN_TAB[ci_reg]);
        dir = vec_reg ? cy_reg[63] : !cz_reg[63];
        x_step = dir ? cx_reg - dx : cx_reg + dx;
        y_step = dir ? cy_reg + dy : cy_reg - dy;
        z_step = dir ? cz_reg - atan_v : cz_reg + atan_v;
    end

    always_comb
    begin
        unique case (job_reg)
            2'd0: rv = 31'($signed(lat1_reg)) - 31'($signed(lat0_reg));
            2'd1: rv = 31'($signed(lon1_reg)) - 31'($signed(lon0_reg));
            2'd2: rv = 31'($signed(lat0_reg));
            default: rv = 31'($signed(lat1_reg));
        endcase
        if (rv >= hda_pkg::DEG_FULL)
        begin
            r1 = rv - hda_pkg::DEG_FULL;
        end
        else if (rv <= -hda_pkg::DEG_FULL)
        begin
            r1 = rv + hda_pkg::DEG_FULL;
        end
        else
        begin
            r1 = rv;
        end
        if (r1 > hda_pkg::DEG_HALF)
        begin
            r2 = r1 - hda_pkg::DEG_FULL;
        end
        else if (r1 < -hda_pkg::DEG_HALF)
        begin
            r2 = r1 + hda_pkg::DEG_FULL;
        end
        else
        begin
            r2 = r1;
        end
        r3 = r2;
        fneg = 1'b0;
        if (job_reg[1])
        begin
            if (r2 > hda_pkg::DEG_QUARTER)
            begin
                r3 = hda_pkg::DEG_HALF - r2;
                fneg = 1'b1;
            end
            else if (r2 < -hda_pkg::DEG_QUARTER)
            begin
                r3 = -hda_pkg::DEG_HALF - r2;
                fneg = 1'b1;
            end
        end
        rmag = r3[30] ? 30'(-r3) : 30'(r3);
    end

    always_comb
    begin
        rem_sh = {sr_rem_reg[61:0], sr_n_reg[121:120]};
        trial = {1'b0, sr_root_reg, 2'b01};
        sr_ge = (rem_sh >= trial);
        root_step = {sr_root_reg[59:0], sr_ge};
        dv_sh = {dv_rem_reg[20:0], dv_q_reg[51]};
        dv_ge = (dv_sh >= {1'b0, count_reg});
        zs = $signed(mul_res);
        z0 = ang_neg_reg ? -zs : zs;
        cm = job_reg[1] ? hda_pkg::mag_clamp(cx_reg) : hda_pkg::mag_clamp(cy_reg);
        a_sum = (c0_neg_reg != c1_neg_reg)
              ? $signed({2'b00, sq_lat_reg}) - $signed({2'b00, mul_res[60:0]})
              : $signed({2'b00, sq_lat_reg}) + $signed({2'b00, mul_res[60:0]});
        if (a_sum[62])
        begin
            ua_c = '0;
        end
        else if (a_sum > $signed({2'b00, hda_pkg::ONE_Q60[60:0]}))
        begin
            ua_c = hda_pkg::ONE_Q60[60:0];
        end
        else
        begin
            ua_c = a_sum[60:0];
        end
        sr_in = (state_reg == hda_pkg::ST_PROD2) ? ua_c : hda_pkg::ONE_Q60[60:0] - ua_reg;
        sr_init = ((122'(sr_in) + 122'd1) << 60) - 122'd1;
        dist_c = mul_res;
        dsat = (dist_c > 64'(hda_pkg::DIST_MAX));
        d32 = dsat ? hda_pkg::DIST_MAX : dist_c[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        mul_ret_next = mul_ret_reg;
        mul_sh_next = mul_sh_reg;
        lon0_next = lon0_reg;
        lon1_next = lon1_reg;
        lat0_next = lat0_reg;
        lat1_next = lat1_reg;
        last_next = last_reg;
        job_next = job_reg;
        ang_neg_next = ang_neg_reg;
        fold_neg_next = fold_neg_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        mul_acc_next = mul_acc_reg;
        mul_cnt_next = mul_cnt_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        ci_next = ci_reg;
        vec_next = vec_reg;
        sq_lat_next = sq_lat_reg;
        sq_lon_next = sq_lon_reg;
        c0_next = c0_reg;
        c0_neg_next = c0_neg_reg;
        c1_neg_next = c1_neg_reg;
        ua_next = ua_reg;
        root_next = root_reg;
        sr_n_next = sr_n_reg;
        sr_rem_next = sr_rem_reg;
        sr_root_next = sr_root_reg;
        sr_cnt_next = sr_cnt_reg;
        sr_second_next = sr_second_reg;
        sum_next = sum_reg;
        count_next = count_reg;
        sat_next = sat_reg;
        dv_q_next = dv_q_reg;
        dv_rem_next = dv_rem_reg;
        dv_cnt_next = dv_cnt_reg;
        radius_next = cfg_wr ? pwdata[30:0] : radius_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_avg_next = out_avg_reg;
        out_cnt_next = out_cnt_reg;
        out_ovf_next = out_ovf_reg;

        unique case (state_reg)
            hda_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    lon0_next = s_axis_tdata[28:0];
                    lat0_next = s_axis_tdata[56:29];
                    lon1_next = s_axis_tdata[85:57];
                    lat1_next = s_axis_tdata[113:86];
                    last_next = s_axis_tlast;
                    job_next = 2'd0;
                    state_next = hda_pkg::ST_PREP;
                end
            end
            hda_pkg::ST_PREP:
            begin
                ang_neg_next = r3[30];
                fold_neg_next = fneg;
                mul_a_next = 64'(rmag);
                mul_b_next = hda_pkg::K_DEG;
                mul_sh_next = hda_pkg::MSH_0;
                mul_acc_next = '0;
                mul_cnt_next = '0;
                mul_ret_next = hda_pkg::ST_ZSET;
                state_next = hda_pkg::ST_MUL;
            end
            hda_pkg::ST_MUL:
            begin
                mul_acc_next = mul_acc_reg + (128'(pp) << {pp_pos, 5'b00000});
                mul_cnt_next = mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == 2'd3)
                begin
                    state_next = mul_ret_reg;
                end
            end
            hda_pkg::ST_ZSET:
            begin
                cx_next = $signed(hda_pkg::INV_GAIN);
                cy_next = '0;
                cz_next = job_reg[1] ? z0 : (z0 >>> 1);
                ci_next = '0;
                vec_next = 1'b0;
                state_next = hda_pkg::ST_CORD;
            end
            hda_pkg::ST_CORD:
            begin
                cx_next = x_step;
                cy_next = y_step;
                cz_next = z_step;
                ci_next = ci_reg + 1'b1;
                if (ci_reg == hda_pkg::CI_W'(hda_pkg::CORDIC_STEPS - 1))
                begin
                    state_next = vec_reg ? hda_pkg::ST_ANG : hda_pkg::ST_RPOST;
                end
            end
            hda_pkg::ST_RPOST:
            begin
                mul_acc_next = '0;
                mul_cnt_next = '0;
                mul_sh_next = hda_pkg::MSH_60;
                if (!job_reg[1])
                begin
                    mul_a_next = 64'(cm);
                    mul_b_next = 64'(cm);
                    mul_ret_next = hda_pkg::ST_SQSAVE;
                    state_next = hda_pkg::ST_MUL;
                end
                else if (!job_reg[0])
                begin
                    c0_next = cm;
                    c0_neg_next = fold_neg_reg && (cm != '0);
                    job_next = 2'd3;
                    state_next = hda_pkg::ST_PREP;
                end
                else
                begin
                    c1_neg_next = fold_neg_reg && (cm != '0);
                    mul_a_next = 64'(c0_reg);
                    mul_b_next = 64'(cm);
                    mul_ret_next = hda_pkg::ST_PROD1;
                    state_next = hda_pkg::ST_MUL;
                end
            end
            hda_pkg::ST_SQSAVE:
            begin
                if (job_reg[0])
                begin
                    sq_lon_next = mul_res[60:0];
                end
                else
                begin
                    sq_lat_next = mul_res[60:0];
                end
                job_next = job_reg + 2'd1;
                state_next = hda_pkg::ST_PREP;
            end
            hda_pkg::ST_PROD1:
            begin
                mul_a_next = mul_res;
                mul_b_next = 64'(sq_lon_reg);
                mul_acc_next = '0;
                mul_cnt_next = '0;
                mul_ret_next = hda_pkg::ST_PROD2;
                state_next = hda_pkg::ST_MUL;
            end
            hda_pkg::ST_PROD2:
            begin
                ua_next = ua_c;
                sr_n_next = sr_init;
                sr_rem_next = '0;
                sr_root_next = '0;
                sr_cnt_next = '0;
                sr_second_next = 1'b0;
                state_next = hda_pkg::ST_SQRT;
            end
            hda_pkg::ST_SQRT:
            begin
                sr_n_next = {sr_n_reg[119:0], 2'b00};
                sr_rem_next = sr_ge ? rem_sh - trial : rem_sh;
                sr_root_next = root_step;
                sr_cnt_next = sr_cnt_reg + 6'd1;
                if (sr_cnt_reg == 6'd60)
                begin
                    if (!sr_second_reg)
                    begin
                        root_next = root_step;
                        sr_n_next = sr_init;
                        sr_rem_next = '0;
                        sr_root_next = '0;
                        sr_cnt_next = '0;
                        sr_second_next = 1'b1;
                    end
                    else
                    begin
                        cx_next = $signed(64'(root_step));
                        cy_next = $signed(64'(root_reg));
                        cz_next = '0;
                        ci_next = '0;
                        vec_next = 1'b1;
                        state_next = hda_pkg::ST_CORD;
                    end
                end
            end
            hda_pkg::ST_ANG:
            begin
                mul_a_next = 64'(radius_reg);
                mul_b_next = cz_reg[63] ? 64'd0 : 64'(cz_reg);
                mul_sh_next = hda_pkg::MSH_59;
                mul_acc_next = '0;
                mul_cnt_next = '0;
                mul_ret_next = hda_pkg::ST_ACC;
                state_next = hda_pkg::ST_MUL;
            end
            hda_pkg::ST_ACC:
            begin
                if (dsat)
                begin
                    sat_next = 1'b1;
                end
                if (count_reg >= hda_pkg::COUNT_LIMIT)
                begin
                    sat_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + 21'd1;
                    if (52'(d32) > (hda_pkg::SUM_MAX - sum_reg))
                    begin
                        sum_next = hda_pkg::SUM_MAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        sum_next = sum_reg + 52'(d32);
                    end
                end
                dv_q_next = sum_next;
                dv_rem_next = '0;
                dv_cnt_next = '0;
                state_next = last_reg ? hda_pkg::ST_DIV : hda_pkg::ST_IDLE;
            end
            hda_pkg::ST_DIV:
            begin
                dv_rem_next = dv_ge ? dv_sh - {1'b0, count_reg} : dv_sh;
                dv_q_next = {dv_q_reg[50:0], dv_ge};
                dv_cnt_next = dv_cnt_reg + 6'd1;
                if (dv_cnt_reg == 6'd51)
                begin
                    state_next = hda_pkg::ST_OUT;
                end
            end
            hda_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next = (count_reg == '0) ? 32'd0 : dv_q_reg[31:0];
                    out_cnt_next = count_reg;
                    out_ovf_next = sat_reg;
                    sum_next = '0;
                    count_next = '0;
                    sat_next = 1'b0;
                    state_next = hda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hda_pkg::ST_IDLE;
            sum_reg <= '0;
            count_reg <= '0;
            sat_reg <= 1'b0;
            radius_reg <= hda_pkg::RADIUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg <= sum_next;
            count_reg <= count_next;
            sat_reg <= sat_next;
            radius_reg <= radius_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_ret_reg <= mul_ret_next;
        mul_sh_reg <= mul_sh_next;
        lon0_reg <= lon0_next;
        lon1_reg <= lon1_next;
        lat0_reg <= lat0_next;
        lat1_reg <= lat1_next;
        last_reg <= last_next;
        job_reg <= job_next;
        ang_neg_reg <= ang_neg_next;
        fold_neg_reg <= fold_neg_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        mul_acc_reg <= mul_acc_next;
        mul_cnt_reg <= mul_cnt_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
        ci_reg <= ci_next;
        vec_reg <= vec_next;
        sq_lat_reg <= sq_lat_next;
        sq_lon_reg <= sq_lon_next;
        c0_reg <= c0_next;
        c0_neg_reg <= c0_neg_next;
        c1_neg_reg <= c1_neg_next;
        ua_reg <= ua_next;
        root_reg <= root_next;
        sr_n_reg <= sr_n_next;
        sr_rem_reg <= sr_rem_next;
        sr_root_reg <= sr_root_next;
        sr_cnt_reg <= sr_cnt_next;
        sr_second_reg <= sr_second_next;
        dv_q_reg <= dv_q_next;
        dv_rem_reg <= dv_rem_next;
        dv_cnt_reg <= dv_cnt_next;
        out_avg_reg <= out_avg_next;
        out_cnt_reg <= out_cnt_next;
        out_ovf_reg <= out_ovf_next;
    end

endmodule

>>> sv/hda_checker.sv
// Port-level checks for the haversine distance average block, bound to its top level.
// Depends on haversine_distance_average_defines.svh for the assertion macros.
`include "haversine_distance_average_defines.svh"

module hda_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        pready
);

    `HDA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after an accepted item")
    `HDA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `HDA_ASSERT_NOW(a_count_nonzero, m_axis_tvalid, m_axis_tdata[52:32] != 21'd0, "result with empty pair count")
    `HDA_ASSERT_NOW(a_pready_high, 1'b1, pready, "configuration port not ready")

endmodule

bind haversine_distance_average hda_checker u_hda_checker (.*);

>>> tb/haversine_checker.sv
`timescale 1ns / 100ps
// Scoreboard for haversine_distance_average: watches the input, output and APB channels.
// Predicts batch averages with its own fixed-point CORDIC model; uses constants from hda_pkg.
module haversine_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [55:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           errors,
    output int           pending,
    output int           pairs_taken,
    output int           averages_checked
);

    typedef struct {
        logic [31:0] avg;
        logic [20:0] count;
        logic        ovf;
    } batch_result_t;

    localparam int STEPS = 32;
    localparam longint DEG_HALF_U = longint'(180) << 20;
    localparam longint DEG_FULL_U = longint'(360) << 20;
    localparam longint DEG_QUART_U = longint'(90) << 20;
    localparam logic [63:0] UNIT_Q60 = 64'd1 << 60;
    localparam logic [63:0] PI_FIX = 64'h3243_F6A8_885A_308D;

    longint        arctan [STEPS];
    longint        gain_comp;
    longint        deg_scale;
    logic [30:0]   radius;
    logic [63:0]   dist_total;
    logic [20:0]   pair_tally;
    logic          sat_seen;
    batch_result_t averages_due [$];

    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return 64'(p >> s);
    endfunction

    function automatic logic [63:0] abs_val(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] limit_one(input logic [63:0] v);
        return (v > UNIT_Q60) ? UNIT_Q60 : v;
    endfunction

    function automatic longint wrap_degrees(input longint d);
        longint m;
        m = d % DEG_FULL_U;
        if (m > DEG_HALF_U)
            m -= DEG_FULL_U;
        if (m < -DEG_HALF_U)
            m += DEG_FULL_U;
        return m;
    endfunction

    task automatic rotate(input longint angle, output longint cosv, output longint sinv);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = gain_comp;
        y = 0;
        z = angle;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan[i];
            end
        end
        cosv = x;
        sinv = y;
    endtask

    function automatic longint vector_angle(input longint yin, input longint xin);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = xin;
        y = yin;
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += arctan[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= arctan[i];
            end
        end
        return z;
    endfunction

    function automatic logic [63:0] root_q60(input logic [63:0] a);
        logic [63:0] r;
        logic [63:0] trial;
        r = '0;
        for (int b = 60; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (mul_shift(trial, trial, 60) <= a)
                r = trial;
        end
        return r;
    endfunction

    task automatic half_sine_sq(input longint d, output logic [63:0] sq);
        longint c;
        longint s;
        logic [63:0] m;
        rotate((wrap_degrees(d) * deg_scale) >>> 1, c, s);
        m = limit_one(abs_val(s));
        sq = mul_shift(m, m, 60);
    endtask

    task automatic latitude_cos(input longint lat, output longint cv);
        longint a;
        longint c;
        longint s;
        bit neg;
        a = wrap_degrees(lat);
        neg = 0;
        if (a > DEG_QUART_U)
        begin
            a = DEG_HALF_U - a;
            neg = 1;
        end
        if (a < -DEG_QUART_U)
        begin
            a = -DEG_HALF_U - a;
            neg = 1;
        end
        rotate(a * deg_scale, c, s);
        cv = longint'(limit_one(abs_val(c)));
        if (neg)
            cv = -cv;
    endtask

    task automatic great_circle(input longint lon0, input longint lat0, input longint lon1,
                                input longint lat1, output logic [63:0] pair_len);
        logic [63:0] sq_lat;
        logic [63:0] sq_lon;
        logic [63:0] prod;
        logic [63:0] ua;
        longint c0;
        longint c1;
        longint a;
        longint ang;
        half_sine_sq(lat1 - lat0, sq_lat);
        half_sine_sq(lon1 - lon0, sq_lon);
        latitude_cos(lat0, c0);
        latitude_cos(lat1, c1);
        prod = mul_shift(mul_shift(abs_val(c0), abs_val(c1), 60), sq_lon, 60);
        a = longint'(sq_lat);
        if ((c0 < 0) != (c1 < 0))
            a -= longint'(prod);
        else
            a += longint'(prod);
        if (a < 0)
            a = 0;
        ua = limit_one(64'(a));
        ang = vector_angle(longint'(root_q60(ua)), longint'(root_q60(UNIT_Q60 - ua)));
        if (ang < 0)
            ang = 0;
        pair_len = mul_shift({33'b0, radius}, 64'(ang), 59);
    endtask

    initial
    begin
        logic [63:0] a2;
        logic [63:0] r;
        longint acc;
        longint term;
        int e;
        for (int i = 0; i < STEPS; i++)
        begin
            acc = 0;
            if (i == 0)
                acc = longint'(PI_FIX >> 2);
            else
                for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++)
                begin
                    e = 60 - i * (2 * k + 1);
                    term = longint'((64'd1 << e) / (2 * k + 1));
                    acc = k[0] ? acc - term : acc + term;
                end
            arctan[i] = acc;
        end
        a2 = UNIT_Q60;
        for (int i = 0; i < STEPS; i++)
            if (2 * i < 61)
                a2 = a2 + (a2 >> (2 * i));
        r = (64'd6 << 60) / 10;
        for (int n = 0; n < 12; n++)
            r = mul_shift(r, (64'd3 << 60) - mul_shift(a2, mul_shift(r, r, 60), 60), 60) >> 1;
        gain_comp = longint'(r);
        deg_scale = longint'((PI_FIX + 64'(DEG_HALF_U / 2)) / 64'(DEG_HALF_U));
    end

    assign pending = averages_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] pair_len;
        batch_result_t exp_res;
        int err_add;
        err_add = 0;
        if (!rst_n)
        begin
            radius <= hda_pkg::RADIUS_RESET;
            dist_total = '0;
            pair_tally = '0;
            sat_seen = 0;
            errors <= 0;
            pairs_taken <= 0;
            averages_checked <= 0;
            averages_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == 3'd0)
                radius <= pwdata[30:0];
            if (s_axis_tvalid && s_axis_tready)
            begin
                pairs_taken <= pairs_taken + 1;
                great_circle($signed(s_axis_tdata[28:0]), $signed(s_axis_tdata[56:29]),
                             $signed(s_axis_tdata[85:57]), $signed(s_axis_tdata[113:86]),
                             pair_len);
                if (pair_len > 64'hFFFF_FFFF)
                begin
                    pair_len = 64'hFFFF_FFFF;
                    sat_seen = 1;
                end
                if (pair_tally >= hda_pkg::COUNT_LIMIT)
                    sat_seen = 1;
                else
                begin
                    pair_tally++;
                    if (pair_len > 64'(hda_pkg::SUM_MAX) - dist_total)
                    begin
                        dist_total = 64'(hda_pkg::SUM_MAX);
                        sat_seen = 1;
                    end
                    else
                        dist_total += pair_len;
                end
                if (s_axis_tlast)
                begin
                    exp_res.avg = (pair_tally != 0) ? 32'(dist_total / pair_tally) : '0;
                    exp_res.count = pair_tally;
                    exp_res.ovf = sat_seen;
                    averages_due.push_back(exp_res);
                    dist_total = '0;
                    pair_tally = '0;
                    sat_seen = 0;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                averages_checked <= averages_checked + 1;
                if (averages_due.size() == 0)
                begin
                    $error("unexpected result: average %0d count %0d overflow %0b",
                           m_axis_tdata[31:0], m_axis_tdata[52:32], m_axis_tuser);
                    err_add++;
                end
                else
                begin
                    exp_res = averages_due.pop_front();
                    if (m_axis_tdata[31:0] !== exp_res.avg)
                    begin
                        $error("average_distance: expected %0d, actual %0d",
                               exp_res.avg, m_axis_tdata[31:0]);
                        err_add++;
                    end
                    if (m_axis_tdata[52:32] !== exp_res.count)
                    begin
                        $error("pair_count: expected %0d, actual %0d",
                               exp_res.count, m_axis_tdata[52:32]);
                        err_add++;
                    end
                    if (m_axis_tuser !== exp_res.ovf)
                    begin
                        $error("overflow: expected %0b, actual %0b", exp_res.ovf, m_axis_tuser);
                        err_add++;
                    end
                end
            end
            errors <= errors + err_add;
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the haversine_distance_average testbench: clock, reset, stimulus and verdict.
// Depends on haversine_checker for prediction and comparison, and on hda_pkg via the block.
module testbench;

    localparam int LON_LIM = 188743680;
    localparam int LAT_LIM = 94371840;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    int           errors;
    int           pending;
    int           pairs_taken;
    int           averages_checked;
    int           send_idle_pct;
    int           stall_pct;
    int           hold_off_left;

    haversine_distance_average dut (.*);

    haversine_checker checker_i
    (
        .clk, .rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .errors, .pending, .pairs_taken, .averages_checked
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic int pick_coord(input int lim, input int width);
        logic [31:0] raw;
        if ($urandom_range(7) == 0)
        begin
            raw = $urandom;
            raw = raw << (32 - width);
            return $signed(raw) >>> (32 - width);
        end
        return $urandom_range(2 * lim) - lim;
    endfunction

    task automatic send_pair(input int lon0, input int lat0, input int lon1, input int lat1,
                             input bit last);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, lat1[27:0], lon1[28:0], lat0[27:0], lon0[28:0]};
        s_axis_tlast <= last;
        do
        begin
            taken = s_axis_tready;
            @(negedge clk);
        end
        while (!taken);
    endtask

    task automatic send_random_pair(input bit last);
        send_pair(pick_coord(LON_LIM, 29), pick_coord(LAT_LIM, 28),
                  pick_coord(LON_LIM, 29), pick_coord(LAT_LIM, 28), last);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_batches();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    initial
    begin
        int remaining;
        int batch_len;
        logic [31:0] radii [4];
        radii = '{32'd1310720000, 32'd1, 32'h7FFF_FFFF, 32'd417647821};
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_left = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_pair(0, 0, 0, 0, 1'b1);
        send_pair(LON_LIM, LAT_LIM, -LON_LIM, -LAT_LIM, 1'b1);
        send_pair(-LON_LIM, -LAT_LIM, LON_LIM, LAT_LIM, 1'b0);
        send_pair(0, 0, LON_LIM, 0, 1'b0);
        send_pair(0, LAT_LIM, 0, -LAT_LIM, 1'b1);
        send_pair(-(1 << 28), -(1 << 27), (1 << 28) - 1, (1 << 27) - 1, 1'b1);
        send_pair((1 << 28) - 1, (1 << 27) - 1, -(1 << 28), -(1 << 27), 1'b0);
        send_pair(12345, 120 << 20, 12345, -(120 << 20), 1'b1);
        send_pair(10 << 20, 45 << 20, 10 << 20, 45 << 20, 1'b1);
        send_pair(0, 0, 1, 0, 1'b1);
        send_pair(90 << 20, 89 << 20, -(90 << 20), 89 << 20, 1'b1);
        send_pair(-(200 << 20), 100 << 20, 200 << 20, -(100 << 20), 1'b1);

        hold_off_left = 3000;
        for (int i = 0; i < 6; i++)
            send_random_pair(1'b1);
        drain_batches();

        for (int phase = 0; phase < 4; phase++)
        begin
            apb_write(3'd0, radii[phase]);
            if (phase == 1)
                apb_write(3'd4, 32'h0000_1234);
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 50 : 25) : 0;
            stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 50 : 25) : 0;
            remaining = 160;
            while (remaining > 0)
            begin
                batch_len = ($urandom_range(9) == 0) ? $urandom_range(12, 25)
                                                     : $urandom_range(1, 6);
                if (batch_len > remaining)
                    batch_len = remaining;
                for (int j = 1; j <= batch_len; j++)
                    send_random_pair(j == batch_len);
                remaining -= batch_len;
            end
            drain_batches();
        end

        $display("Covered %0d coordinate pairs and %0d batch averages over four radius",
                 pairs_taken, averages_checked);
        $display("settings, including radius extremes, with input gaps and output stalls.");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
